/* rtl/mvw_pkg.sv */
// shared types and constants for the momentum volatility weight unit
// no dependencies
package mvw_pkg;

  localparam int PRICE_W   = 48;
  localparam int REG_W     = 9;
  localparam int VOL_W     = 32;
  localparam int WEIGHT_W  = 32;
  localparam int RET_W     = 32;
  localparam int SUM_W     = 40;
  localparam int RET_FRAC  = 24;
  localparam int NUM_W     = 72;
  localparam int DEN_W     = 64;
  localparam int SCALE_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0]   MLB_RESET     = 9'd252;
  localparam logic [REG_W-1:0]   VLB_RESET     = 9'd60;
  localparam logic [REG_W-1:0]   MIN_WINDOW    = 9'd2;
  localparam logic [29:0]        RET_MAX       = 30'h3FFF_FFFF;
  localparam logic [SCALE_W-1:0] ANNUAL_SCALE  = 16'd64512;  // 252 * 256
  localparam logic [VOL_W-1:0]   VOL_SAT       = 32'hFFFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_NEG_MAX = 32'h8000_0000;
  localparam logic [40:0]        RECIP_ONE     = 41'h100_0000_0000;

  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOMENTUM   = 2'd0,
    REG_VOLATILITY = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DSEL_RET   = 2'd0,
    DSEL_MEAN  = 2'd1,
    DSEL_VAR   = 2'd2,
    DSEL_RECIP = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     set_fail;
    logic     rd_ref;
    logic     latch_ref;
    logic     latch_newest;
    logic     latch_prev;
    logic     div_start;
    div_sel_t div_sel;
    logic     ret_done;
    logic     clr_j;
    logic     inc_j;
    logic     mean_done;
    logic     dev_abs;
    logic     dev_sq;
    logic     dev_acc;
    logic     var_done;
    logic     scale;
    logic     sqrt_step;
    logic     recip_done;
  } mvw_cmd_t;

  typedef struct packed {
    logic chk_fail;
    logic zero_close;
    logic j_zero;
    logic j_last;
    logic k_last;
    logic div_done;
    logic sqrt_last;
    logic weight_needed;
  } mvw_stat_t;

endpackage

/* rtl/momentum_volatility_weight_unit.sv */
// top level of the momentum volatility weight unit
// depends on mvw_pkg, mvw_ctrl, mvw_dp (which uses mvw_ram and mvw_div)
// a close without evaluate is stored while the unit stays idle; busy stays low, next close next cycle
// an evaluation holds busy through all of its phases; the reciprocal division is skipped when
// the weight is zero and a failure ends it early; most of it goes to the shared divider (per return,
// mean, variance, reciprocal) and a 32-step square root; done pulses one cycle, no stall
// synchronous reset: lookbacks to 252 and 60, history emptied, history ram not cleared
module momentum_volatility_weight_unit #(
  parameter int HISTORY_DEPTH = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  // item command
  input  logic                                start,
  output logic                                busy,
  input  logic [mvw_pkg::PRICE_W-1:0]         close_price,
  input  logic                                new_series,
  input  logic                                evaluate,
  // result word
  output logic                                done,
  output logic                                valid_signal,
  output logic signed [1:0]                   momentum_sign,
  output logic [mvw_pkg::VOL_W-1:0]           annual_volatility,
  output logic signed [mvw_pkg::WEIGHT_W-1:0] position_weight,
  // config write port
  input  logic                                cfg_write,
  input  logic [mvw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mvw_pkg::REG_W-1:0]           cfg_data
);
  import mvw_pkg::*;

  mvw_cmd_t  cmd;
  mvw_stat_t stat;

  // controller walks: check, reference close, window returns, mean, deviations,
  // variance, scale and sqrt, reciprocal
  mvw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .evaluate (evaluate),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  // datapath holds the history ring, config and all arithmetic
  mvw_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .close_price       (close_price),
    .new_series        (new_series),
    .valid_signal      (valid_signal),
    .momentum_sign     (momentum_sign),
    .annual_volatility (annual_volatility),
    .position_weight   (position_weight)
  );

  // result strobe only comes out of an evaluation in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");

  // a failed evaluation carries zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_signal) |->
      (momentum_sign == 2'sb00 && annual_volatility == '0 && position_weight == '0))
    else $error("failed result with nonzero fields");

  // a rising signal never gets a negative weight
  a_pos_weight: assert property (@(posedge clk) disable iff (rst)
    (done && valid_signal && momentum_sign == 2'sb01) |-> !position_weight[WEIGHT_W-1])
    else $error("positive momentum with negative weight");

endmodule

/* rtl/mvw_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module mvw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mvw_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on mvw_pkg
module mvw_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mvw_pkg::NUM_W-1:0]  num,
  input  logic [mvw_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [mvw_pkg::NUM_W-1:0]  quo
);
  import mvw_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] divisor;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem, quo[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num;
      rem     <= '0;
      divisor <= den;
    end else if (running) begin
      if (fits) begin
        rem <= DEN_W'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/mvw_ctrl.sv */
// sequencing state machine for store, window walk and result phases
// depends on mvw_pkg
module mvw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               evaluate,
  input  mvw_pkg::mvw_stat_t stat,
  output mvw_pkg::mvw_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import mvw_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_CHECK    = 20'h00002,
    S_REF_RD   = 20'h00004,
    S_REF_GOT  = 20'h00008,
    S_WIN_RD   = 20'h00010,
    S_WIN_GOT  = 20'h00020,
    S_RET_DIV  = 20'h00040,
    S_MEAN_GO  = 20'h00080,
    S_MEAN_DIV = 20'h00100,
    S_DEV_RD   = 20'h00200,
    S_DEV_ABS  = 20'h00400,
    S_DEV_SQ   = 20'h00800,
    S_DEV_ACC  = 20'h01000,
    S_VAR_GO   = 20'h02000,
    S_VAR_DIV  = 20'h04000,
    S_SCALE    = 20'h08000,
    S_SQRT     = 20'h10000,
    S_WEIGHT   = 20'h20000,
    S_RECIP    = 20'h40000,
    S_DONE     = 20'h80000
  } state_t;

  state_t state, state_next;

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (evaluate) state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clr_j = 1'b1;
        if (stat.chk_fail) begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end else begin
          state_next = S_REF_RD;
        end
      end
      S_REF_RD: begin
        cmd.rd_ref = 1'b1;
        state_next = S_REF_GOT;
      end
      S_REF_GOT: begin
        cmd.latch_ref = 1'b1;
        if (stat.zero_close) begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end else begin
          state_next = S_WIN_RD;
        end
      end
      S_WIN_RD: state_next = S_WIN_GOT;
      S_WIN_GOT: begin
        if (stat.zero_close) begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end else if (stat.j_zero) begin
          cmd.latch_newest = 1'b1;
          cmd.inc_j        = 1'b1;
          state_next       = S_WIN_RD;
        end else begin
          cmd.latch_prev = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel    = DSEL_RET;
          state_next     = S_RET_DIV;
        end
      end
      S_RET_DIV: begin
        if (stat.div_done) begin
          cmd.ret_done = 1'b1;
          if (stat.j_last) begin
            cmd.clr_j  = 1'b1;
            state_next = S_MEAN_GO;
          end else begin
            cmd.inc_j  = 1'b1;
            state_next = S_WIN_RD;
          end
        end
      end
      S_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MEAN;
        state_next    = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        if (stat.div_done) begin
          cmd.mean_done = 1'b1;
          state_next    = S_DEV_RD;
        end
      end
      S_DEV_RD: state_next = S_DEV_ABS;
      S_DEV_ABS: begin
        cmd.dev_abs = 1'b1;
        state_next  = S_DEV_SQ;
      end
      S_DEV_SQ: begin
        cmd.dev_sq = 1'b1;
        state_next = S_DEV_ACC;
      end
      S_DEV_ACC: begin
        cmd.dev_acc = 1'b1;
        if (stat.k_last) begin
          state_next = S_VAR_GO;
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = S_DEV_RD;
        end
      end
      S_VAR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_VAR;
        state_next    = S_VAR_DIV;
      end
      S_VAR_DIV: begin
        if (stat.div_done) begin
          cmd.var_done = 1'b1;
          state_next   = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_next = S_WEIGHT;
      end
      S_WEIGHT: begin
        if (stat.weight_needed) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_RECIP;
          state_next    = S_RECIP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RECIP: begin
        if (stat.div_done) begin
          cmd.recip_done = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/mvw_dp.sv */
// datapath: history ring, return buffer, divider, sqrt and result registers
// depends on mvw_pkg, mvw_ram, mvw_div
module mvw_dp #(
  parameter int HISTORY_DEPTH = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mvw_pkg::mvw_cmd_t               cmd,
  output mvw_pkg::mvw_stat_t              stat,
  input  logic                            cfg_write,
  input  logic [mvw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvw_pkg::REG_W-1:0]       cfg_data,
  input  logic [mvw_pkg::PRICE_W-1:0]     close_price,
  input  logic                            new_series,
  output logic                            valid_signal,
  output logic signed [1:0]               momentum_sign,
  output logic [mvw_pkg::VOL_W-1:0]       annual_volatility,
  output logic signed [mvw_pkg::WEIGHT_W-1:0] position_weight
);
  import mvw_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CW   = AW + 1;
  localparam int KW   = (AW > REG_W) ? AW : REG_W;
  localparam int CMPW = (CW > REG_W + 1) ? CW : REG_W + 1;

  logic [REG_W-1:0] mlb, vlb;
  logic [AW-1:0]    wp;
  logic [CW-1:0]    count;
  logic [KW-1:0]    j;
  logic             fail;

  logic [PRICE_W-1:0] ref_close, cur, prev;
  logic               up;
  logic [1:0]         sign;
  logic signed [SUM_W-1:0] sum;
  logic signed [RET_W-1:0] mean;
  logic [RET_W-1:0]   dev;
  logic [63:0]        prod, sumsq, var_q;
  logic [63:0]        sq_x, sq_res, sq_bit;
  logic               sq_ovf;
  logic [VOL_W-1:0]   vol;
  logic [WEIGHT_W-1:0] weight;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mlb <= MLB_RESET;
      vlb <= VLB_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MOMENTUM:   mlb <= cfg_data;
        REG_VOLATILITY: vlb <= cfg_data;
        default: ;
      endcase
    end
  end

  // history ring write side
  logic [AW-1:0] store_addr;
  assign store_addr = new_series ? '0 : wp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      wp <= (store_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : store_addr + AW'(1);
      if (new_series) begin
        count <= CW'(1);
      end else if (count != CW'(HISTORY_DEPTH)) begin
        count <= count + CW'(1);
      end
    end
  end

  // address of the close k sessions back
  logic [KW-1:0]   back_k;
  logic [KW+1:0]   back_raw, back_wrap;
  logic [AW-1:0]   close_raddr;
  logic [PRICE_W-1:0] close_rdata;

  assign back_k    = cmd.rd_ref ? KW'(mlb) : j;
  assign back_raw  = (KW+2)'(wp) + (KW+2)'(HISTORY_DEPTH - 1) - (KW+2)'(back_k);
  assign back_wrap = (back_raw >= (KW+2)'(HISTORY_DEPTH)) ?
                     back_raw - (KW+2)'(HISTORY_DEPTH) : back_raw;
  assign close_raddr = back_wrap[AW-1:0];

  mvw_ram #(.WIDTH(PRICE_W), .DEPTH(HISTORY_DEPTH)) u_close_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (store_addr),
    .wdata (close_price),
    .raddr (close_raddr),
    .rdata (close_rdata)
  );

  // return buffer
  logic [KW-1:0]    j_m1;
  logic [RET_W-1:0] ret_val, ret_rdata;
  assign j_m1 = j - KW'(1);

  mvw_ram #(.WIDTH(RET_W), .DEPTH(HISTORY_DEPTH)) u_ret_ram (
    .clk   (clk),
    .we    (cmd.ret_done),
    .waddr (j_m1[AW-1:0]),
    .wdata (ret_val),
    .raddr (j[AW-1:0]),
    .rdata (ret_rdata)
  );

  // shared divider
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [PRICE_W-1:0] diff;
  logic             up_now;
  logic [SUM_W-1:0] sum_abs;

  assign up_now  = cur >= close_rdata;
  assign diff    = up_now ? cur - close_rdata : close_rdata - cur;
  assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_comb begin
    case (cmd.div_sel)
      DSEL_RET: begin
        div_num = {diff, {RET_FRAC{1'b0}}};
        div_den = DEN_W'(close_rdata);
      end
      DSEL_MEAN: begin
        div_num = NUM_W'(sum_abs);
        div_den = DEN_W'(vlb);
      end
      DSEL_VAR: begin
        div_num = NUM_W'(sumsq);
        div_den = DEN_W'(vlb - REG_W'(1));
      end
      DSEL_RECIP: begin
        div_num = NUM_W'(RECIP_ONE + 41'(vol >> 1));
        div_den = DEN_W'(vol);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  mvw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // return saturation and sign
  logic [29:0]      ret_mag;
  assign ret_mag = (|div_quo[NUM_W-1:30]) ? RET_MAX : div_quo[29:0];
  assign ret_val = up ? RET_W'(ret_mag) : RET_W'(-RET_W'(ret_mag));

  // deviation
  logic signed [RET_W:0] dev_d;
  assign dev_d = $signed({ret_rdata[RET_W-1], ret_rdata}) - $signed({mean[RET_W-1], mean});

  // sqrt step
  logic [63:0] sq_t, sq_res_next;
  logic        sq_fit;
  logic [79:0] wide;
  assign sq_t   = sq_res + sq_bit;
  assign sq_fit = sq_x >= sq_t;
  assign sq_res_next = sq_fit ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  assign wide   = var_q * ANNUAL_SCALE;

  // reciprocal magnitude
  logic [40:0] mag;
  assign mag = div_quo[40:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      j    <= '0;
      fail <= 1'b0;
    end else begin
      if (cmd.accept) fail <= 1'b0;
      else if (cmd.set_fail) fail <= 1'b1;
      if (cmd.clr_j) j <= '0;
      else if (cmd.inc_j) j <= j + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_ref) ref_close <= close_rdata;
    if (cmd.latch_newest) begin
      cur <= close_rdata;
      if (close_rdata > ref_close) sign <= SIGN_POS;
      else if (close_rdata < ref_close) sign <= SIGN_NEG;
      else sign <= SIGN_ZERO;
    end
    if (cmd.clr_j && !cmd.ret_done) begin
      sum   <= '0;
      sumsq <= '0;
    end
    if (cmd.latch_prev) begin
      prev <= close_rdata;
      up   <= up_now;
    end
    if (cmd.ret_done) begin
      sum <= sum + SUM_W'(signed'(ret_val));
      cur <= prev;
    end
    if (cmd.mean_done) begin
      mean <= sum[SUM_W-1] ? RET_W'(-div_quo[RET_W-1:0]) : div_quo[RET_W-1:0];
    end
    if (cmd.dev_abs) dev <= dev_d[RET_W] ? RET_W'(-dev_d) : RET_W'(dev_d);
    if (cmd.dev_sq) prod <= 64'(dev) * 64'(dev);
    if (cmd.dev_acc) sumsq <= sumsq + {8'b0, prod[63:8]};
    if (cmd.var_done) var_q <= div_quo[63:0];
    if (cmd.scale) begin
      sq_x   <= wide[63:0];
      sq_ovf <= |wide[79:64];
      sq_res <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
      weight <= '0;
    end
    if (cmd.sqrt_step) begin
      if (sq_fit) sq_x <= sq_x - sq_t;
      sq_res <= sq_res_next;
      sq_bit <= sq_bit >> 2;
      if (sq_bit[0]) vol <= sq_ovf ? VOL_SAT : sq_res_next[VOL_W-1:0];
    end
    if (cmd.recip_done) begin
      if (sign == SIGN_POS) begin
        weight <= (mag > 41'(WEIGHT_POS_MAX)) ? WEIGHT_POS_MAX : mag[WEIGHT_W-1:0];
      end else begin
        weight <= (mag >= 41'(WEIGHT_NEG_MAX)) ? WEIGHT_NEG_MAX :
                  WEIGHT_W'(-mag[WEIGHT_W-1:0]);
      end
    end
  end

  // status
  logic [CMPW-1:0] cnt_x;
  assign cnt_x = CMPW'(count);

  always_comb begin
    stat.chk_fail = (cnt_x < CMPW'(mlb) + CMPW'(1)) || (vlb < MIN_WINDOW) ||
                    (cnt_x < CMPW'(vlb) + CMPW'(1));
    stat.zero_close    = close_rdata == '0;
    stat.j_zero        = j == '0;
    stat.j_last        = j == KW'(vlb);
    stat.k_last        = j == KW'(vlb - REG_W'(1));
    stat.div_done      = div_done;
    stat.sqrt_last     = sq_bit[0];
    stat.weight_needed = (vol != '0) && (sign != SIGN_ZERO);
  end

  assign valid_signal      = !fail;
  assign momentum_sign     = fail ? 2'sb00 : signed'(sign);
  assign annual_volatility = fail ? '0 : vol;
  assign position_weight   = fail ? '0 : signed'(weight);

endmodule
